/* design/rgbhsv_pkg.sv */
// Package for the RGB to HSV pixel converter: component and fraction widths,
// divider datapath types and the restoring divide step. No dependencies.
`timescale 1ns / 1ps

package rgbhsv_pkg;

  localparam int COMPONENT_BITS = 8;
  localparam int FRACTION_BITS  = 16;

  // Both quotients run through FRACTION_BITS + 1 divide steps.
  localparam int QUO_BITS = FRACTION_BITS + 1;
  // The hue divisor 6*C needs three bits above a component.
  localparam int HUE_BITS = COMPONENT_BITS + 3;
  // A partial remainder is below the divisor and is doubled once per step.
  localparam int REM_BITS = COMPONENT_BITS + 4;

  typedef logic [COMPONENT_BITS-1:0] comp_t;
  typedef logic [HUE_BITS-1:0]       hnum_t;
  typedef logic [REM_BITS-1:0]       rem_t;
  typedef logic [QUO_BITS-1:0]       quo_t;

  typedef struct packed {
    rem_t rem;
    logic qbit;
  } step_t;

  // One restoring division step. The first step compares the remainder as
  // it stands; later steps double it first.
  function automatic step_t div_step(rem_t rem, rem_t dvs, logic first);
    rem_t  t;
    step_t s;
    t = first ? rem : {rem[REM_BITS-2:0], 1'b0};
    s.qbit = (t >= dvs);
    s.rem  = s.qbit ? rem_t'(t - dvs) : t;
    return s;
  endfunction

endpackage

/* design/rgb_to_hsv_pixel_top.sv */
// Top level of the RGB to HSV pixel converter: input register, sector and
// chroma stages, and two lockstep pipelined restoring dividers.
// Depends on rgbhsv_pkg.
`timescale 1ns / 1ps

// Usage:
// An item (red, green, blue) is taken at each rising edge where start is high
// and busy is low. busy stays low, so a pixel may enter on every clock.
// Each item gives one result (hue, saturation, value), shown for exactly one
// cycle with done high. The result of an item passes through 3 front stages
// plus FRACTION_BITS + 1 divider stages (20 register stages for the default
// widths). Throughput is one item per clock: every divider stage resolves one
// quotient bit of both the saturation and the hue quotient with one compare
// and subtract on a narrow remainder.
// Hue is the fraction of a turn in units of 2^-FRACTION_BITS, saturation is
// C/V in the same units with 2^FRACTION_BITS meaning 1.0, value is the
// largest component. Gray pixels give hue 0, black pixels saturation 0.
// Synchronous reset clears the valid bits of every stage, so items in flight
// are dropped and no done strobe follows. The receiver cannot stall; results
// leave the pipeline in the order the items came in.
module rgb_to_hsv_pixel_top (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] red,
  input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] green,
  input  logic [rgbhsv_pkg::COMPONENT_BITS-1:0] blue,
  output logic                                 done,
  output logic [rgbhsv_pkg::FRACTION_BITS-1:0]  hue,
  output logic [rgbhsv_pkg::QUO_BITS-1:0]       saturation,
  output logic [rgbhsv_pkg::COMPONENT_BITS-1:0] value
);

  localparam int NS = rgbhsv_pkg::QUO_BITS;
  localparam int FB = rgbhsv_pkg::FRACTION_BITS;

  typedef enum logic [1:0] {SEC_RED, SEC_GREEN, SEC_BLUE} sector_t;

  // Stage 0: input register.
  logic              s0_valid;
  rgbhsv_pkg::comp_t s0_r, s0_g, s0_b;

  // Stage 1: maximum, chroma and sector.
  logic              s1_valid;
  rgbhsv_pkg::comp_t s1_r, s1_g, s1_b, s1_v, s1_c;
  sector_t           s1_sec;
  rgbhsv_pkg::comp_t s1_v_next, s1_min_next;
  sector_t           s1_sec_next;

  // Stage 2: divider operands.
  logic              s2_valid;
  rgbhsv_pkg::comp_t s2_v;
  rgbhsv_pkg::rem_t  s2_hrem, s2_hdiv, s2_srem, s2_sdiv;
  rgbhsv_pkg::hnum_t s2_hnum_next, s2_hden_next;
  rgbhsv_pkg::hnum_t c_ext, r_ext, g_ext, b_ext;

  // Divider stages, one quotient bit of each divider per stage.
  logic              dv_valid [NS];
  rgbhsv_pkg::comp_t dv_v     [NS];
  rgbhsv_pkg::rem_t  dv_hrem  [NS];
  rgbhsv_pkg::rem_t  dv_hdiv  [NS];
  rgbhsv_pkg::rem_t  dv_srem  [NS];
  rgbhsv_pkg::rem_t  dv_sdiv  [NS];
  rgbhsv_pkg::quo_t  dv_hq    [NS];
  rgbhsv_pkg::quo_t  dv_sq    [NS];
  rgbhsv_pkg::step_t h_step   [NS];
  rgbhsv_pkg::step_t s_step   [NS];

  assign busy = 1'b0;

  always_comb begin
    if (s0_r >= s0_g && s0_r >= s0_b) begin
      s1_sec_next = SEC_RED;
      s1_v_next   = s0_r;
    end else if (s0_g >= s0_b) begin
      s1_sec_next = SEC_GREEN;
      s1_v_next   = s0_g;
    end else begin
      s1_sec_next = SEC_BLUE;
      s1_v_next   = s0_b;
    end
    s1_min_next = s0_r;
    if (s0_g < s1_min_next) begin
      s1_min_next = s0_g;
    end
    if (s0_b < s1_min_next) begin
      s1_min_next = s0_b;
    end
  end

  // The hue numerator is nonnegative in every sector, so modular arithmetic
  // at this width gives it exactly.
  always_comb begin
    c_ext = rgbhsv_pkg::hnum_t'(s1_c);
    r_ext = rgbhsv_pkg::hnum_t'(s1_r);
    g_ext = rgbhsv_pkg::hnum_t'(s1_g);
    b_ext = rgbhsv_pkg::hnum_t'(s1_b);
    s2_hden_next = (c_ext << 2) + (c_ext << 1);
    unique case (s1_sec)
      SEC_RED: begin
        if (g_ext >= b_ext) begin
          s2_hnum_next = g_ext - b_ext;
        end else begin
          s2_hnum_next = s2_hden_next - (b_ext - g_ext);
        end
      end
      SEC_GREEN: s2_hnum_next = (c_ext << 1) + b_ext - r_ext;
      SEC_BLUE:  s2_hnum_next = (c_ext << 2) + r_ext - g_ext;
      default:   s2_hnum_next = '0;
    endcase
    // A zero divisor only occurs with a zero dividend; divide by one instead.
    if (s1_c == '0) begin
      s2_hden_next = rgbhsv_pkg::hnum_t'(1);
    end
  end

  always_comb begin
    for (int k = 0; k < NS; k++) begin
      if (k == 0) begin
        h_step[k] = rgbhsv_pkg::div_step(s2_hrem, s2_hdiv, 1'b1);
        s_step[k] = rgbhsv_pkg::div_step(s2_srem, s2_sdiv, 1'b1);
      end else begin
        h_step[k] = rgbhsv_pkg::div_step(dv_hrem[k-1], dv_hdiv[k-1], 1'b0);
        s_step[k] = rgbhsv_pkg::div_step(dv_srem[k-1], dv_sdiv[k-1], 1'b0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      for (int k = 0; k < NS; k++) begin
        dv_valid[k] <= 1'b0;
      end
    end else begin
      s0_valid <= start && !busy;
      s1_valid <= s0_valid;
      s2_valid <= s1_valid;
      dv_valid[0] <= s2_valid;
      for (int k = 1; k < NS; k++) begin
        dv_valid[k] <= dv_valid[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= red;
    s0_g <= green;
    s0_b <= blue;

    s1_r   <= s0_r;
    s1_g   <= s0_g;
    s1_b   <= s0_b;
    s1_v   <= s1_v_next;
    s1_c   <= s1_v_next - s1_min_next;
    s1_sec <= s1_sec_next;

    s2_v    <= s1_v;
    s2_hrem <= rgbhsv_pkg::rem_t'(s2_hnum_next);
    s2_hdiv <= rgbhsv_pkg::rem_t'(s2_hden_next);
    s2_srem <= rgbhsv_pkg::rem_t'(s1_c);
    s2_sdiv <= (s1_v == '0) ? rgbhsv_pkg::rem_t'(1) : rgbhsv_pkg::rem_t'(s1_v);

    for (int k = 0; k < NS; k++) begin
      dv_hrem[k] <= h_step[k].rem;
      dv_srem[k] <= s_step[k].rem;
      if (k == 0) begin
        dv_v[k]    <= s2_v;
        dv_hdiv[k] <= s2_hdiv;
        dv_sdiv[k] <= s2_sdiv;
        dv_hq[k]   <= rgbhsv_pkg::quo_t'(h_step[k].qbit);
        dv_sq[k]   <= rgbhsv_pkg::quo_t'(s_step[k].qbit);
      end else begin
        dv_v[k]    <= dv_v[k-1];
        dv_hdiv[k] <= dv_hdiv[k-1];
        dv_sdiv[k] <= dv_sdiv[k-1];
        dv_hq[k]   <= {dv_hq[k-1][NS-2:0], h_step[k].qbit};
        dv_sq[k]   <= {dv_sq[k-1][NS-2:0], s_step[k].qbit};
      end
    end
  end

  // The top hue quotient bit is always zero because the numerator is below
  // the divisor.
  assign done       = dv_valid[NS-1];
  assign hue        = dv_hq[NS-1][FB-1:0];
  assign saturation = dv_sq[NS-1];
  assign value      = dv_v[NS-1];

endmodule
